// ===== src/sdq_pkg.sv =====
// Package for the sorted double-ended queue: operation and status codes,
// channel payload structs and the control struct broadcast to the cell row.
// No dependencies.
package sdq_pkg;

  localparam int unsigned VAL_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_POP_MIN = 2'd1,
    OP_POP_MAX = 2'd2,
    OP_CLEAR   = 2'd3
  } sdq_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } sdq_status_t;

  typedef struct packed {
    sdq_op_t                   operation;
    logic signed [VAL_W-1:0]   item_value;
  } sdq_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]   result_value;
    logic [1:0]                status;
    logic [4:0]                entry_count;
  } sdq_out_t;

  // Broadcast to every cell; apply qualifies the update.
  typedef struct packed {
    logic                      apply;
    sdq_op_t                   op;
    logic signed [VAL_W-1:0]   value;
  } sdq_ctrl_t;

endpackage

// ===== src/sdq_cell.sv =====
// One storage cell of the sorted row: a value and its valid bit.
// Depends on sdq_pkg; besides the broadcast control, talks to its left and right neighbors only.
module sdq_cell import sdq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sdq_ctrl_t               ctrl,
  input  logic                    left_valid,
  input  logic                    left_gt,
  input  logic signed [VAL_W-1:0] left_value,
  input  logic                    right_valid,
  input  logic signed [VAL_W-1:0] right_value,
  output logic                    valid_o,
  output logic signed [VAL_W-1:0] value_o,
  output logic                    gt_o
);

  logic                    valid_r, valid_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;

  // Strictly greater, so an equal value lands after the ones already held.
  assign gt_o    = valid_r && (value_r > ctrl.value);
  assign valid_o = valid_r;
  assign value_o = value_r;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctrl.apply) begin
      unique case (ctrl.op)
        OP_INSERT: begin
          valid_nxt = valid_r | left_valid;
          if (left_gt) begin
            value_nxt = left_value;
          end else if (gt_o || (!valid_r && left_valid)) begin
            value_nxt = ctrl.value;
          end
        end
        OP_POP_MIN: begin
          valid_nxt = right_valid;
          value_nxt = right_value;
        end
        OP_POP_MAX: begin
          valid_nxt = valid_r & right_valid;
        end
        OP_CLEAR: begin
          valid_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ===== src/sdq_max_tree.sv =====
// Registered OR tree that picks the value of the last valid cell.
// Depends on sdq_pkg; one register level per tree level, free running.
module sdq_max_tree import sdq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk,
  input  logic [DEPTH-1:0]                  valid_vec,
  input  logic [DEPTH-1:0][VAL_W-1:0]       values,
  output logic [VAL_W-1:0]                  tail_value
);

  localparam int unsigned LEVELS = $clog2(DEPTH);
  localparam int unsigned LEAVES = 2 ** LEVELS;

  logic [VAL_W-1:0] leaf  [LEAVES];
  logic [VAL_W-1:0] node_r[1:LEAVES-1];

  // Only the last valid cell contributes, so an OR of all leaves selects it.
  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < DEPTH - 1) begin : g_mid
      assign leaf[j] = (valid_vec[j] && !valid_vec[j+1]) ? values[j] : '0;
    end else if (j == DEPTH - 1) begin : g_end
      assign leaf[j] = valid_vec[j] ? values[j] : '0;
    end else begin : g_pad
      assign leaf[j] = '0;
    end
  end

  for (genvar k = 1; k < LEAVES; k++) begin : g_node
    if (2 * k >= LEAVES) begin : g_bottom
      always_ff @(posedge clk) begin
        node_r[k] <= leaf[2*k-LEAVES] | leaf[2*k+1-LEAVES];
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        node_r[k] <= node_r[2*k] | node_r[2*k+1];
      end
    end
  end

  assign tail_value = node_r[1];

endmodule

// ===== src/sorted_double_ended_queue.sv =====
// Sorted double-ended queue: holds up to DEPTH signed 32-bit values in ascending
// order in a row of cells, where each cell decides its next content from its two
// neighbors. Insert, remove-smallest and clear update the row when accepted, so these
// transactions can be accepted back to back while the output register drains.
// Remove-largest waits while the tail value is collected by a registered OR tree
// with one register level per tree level, and only then is the row updated. There
// is no clearing pass after reset; the valid bits clear at once.
module sorted_double_ended_queue import sdq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sdq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sdq_out_t out_data
);

  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned LEVELS = $clog2(DEPTH);
  localparam int unsigned WCW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WAIT = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [WCW-1:0]       wait_r, wait_nxt;
  logic                 out_valid_r, out_valid_nxt;
  sdq_out_t             out_data_r, out_data_nxt;

  sdq_ctrl_t                      ctrl;
  logic [DEPTH-1:0]               cell_valid;
  logic [DEPTH-1:0]               cell_gt;
  logic [DEPTH-1:0][VAL_W-1:0]    cell_value;
  logic [VAL_W-1:0]               tail_value;

  logic accept, out_free, full, empty;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    wait_nxt      = wait_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ctrl.apply    = 1'b0;
    ctrl.op       = in_data.operation;
    ctrl.value    = in_data.item_value;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_data_nxt.result_value = '0;
          out_data_nxt.status       = ST_OK;
          out_valid_nxt             = 1'b1;
          unique case (in_data.operation)
            OP_INSERT: begin
              out_data_nxt.result_value = in_data.item_value;
              if (full) begin
                out_data_nxt.status = ST_FULL;
              end else begin
                ctrl.apply = 1'b1;
                cnt_nxt    = cnt_r + 1'b1;
              end
            end
            OP_POP_MIN: begin
              if (empty) begin
                out_data_nxt.status = ST_EMPTY;
              end else begin
                ctrl.apply                = 1'b1;
                out_data_nxt.result_value = cell_value[0];
                cnt_nxt                   = cnt_r - 1'b1;
              end
            end
            OP_POP_MAX: begin
              if (empty) begin
                out_data_nxt.status = ST_EMPTY;
              end else begin
                // The row stays frozen until the tree has settled on it.
                out_valid_nxt = 1'b0;
                wait_nxt      = '0;
                state_nxt     = S_WAIT;
              end
            end
            OP_CLEAR: begin
              ctrl.apply = 1'b1;
              cnt_nxt    = '0;
            end
          endcase
        end
      end
      S_WAIT: begin
        ctrl.op = OP_POP_MAX;
        if (wait_r != WCW'(LEVELS - 1)) begin
          wait_nxt = wait_r + 1'b1;
        end else if (out_free) begin
          ctrl.apply                = 1'b1;
          cnt_nxt                   = cnt_r - 1'b1;
          out_valid_nxt             = 1'b1;
          out_data_nxt.result_value = tail_value;
          out_data_nxt.status       = ST_OK;
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_data_nxt.entry_count = 5'(cnt_nxt);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    left_valid, left_gt, right_valid;
    logic signed [VAL_W-1:0] left_value, right_value, own_value;

    if (i == 0) begin : g_first
      assign left_valid = 1'b1;
      assign left_gt    = 1'b0;
      assign left_value = '0;
    end else begin : g_left
      assign left_valid = cell_valid[i-1];
      assign left_gt    = cell_gt[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_valid = 1'b0;
      assign right_value = own_value;
    end else begin : g_right
      assign right_valid = cell_valid[i+1];
      assign right_value = cell_value[i+1];
    end

    sdq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .left_valid  (left_valid),
      .left_gt     (left_gt),
      .left_value  (left_value),
      .right_valid (right_valid),
      .right_value (right_value),
      .valid_o     (cell_valid[i]),
      .value_o     (own_value),
      .gt_o        (cell_gt[i])
    );

    assign cell_value[i] = own_value;
  end

  sdq_max_tree #(.DEPTH(DEPTH)) u_tree (
    .clk        (clk),
    .valid_vec  (cell_valid),
    .values     (cell_value),
    .tail_value (tail_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The valid cells must always be exactly the first cnt_r cells.
  logic [DEPTH-1:0] prefix_ok;
  for (genvar i = 0; i < DEPTH; i++) begin : g_prefix
    assign prefix_ok[i] = (cell_valid[i] == (CW'(i) < cnt_r));
  end

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    &prefix_ok)
    else $error("cell valid bits do not match the entry count");

  a_wait_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT) |-> (cnt_r != '0))
    else $error("remove-largest pending on an empty store");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.operation == OP_INSERT && !full)
      |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("insert did not grow the entry count");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_FULL) |-> (cnt_r == CW'(DEPTH)))
    else $error("full status reported while the store is not full");

endmodule

// ===== bench/sorted_double_ended_queue_test.sv =====
// Self-checking testbench for the sorted double-ended queue: random and directed operations
// are checked against a behavioral sorted-list predictor with random stalls on both channels.
// Depends on sdq_pkg and sorted_double_ended_queue.
module sorted_double_ended_queue_test import sdq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = 16;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 20;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  sdq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sdq_out_t out_data;

  sorted_double_ended_queue #(.DEPTH(QDEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  // Predictor state: ascending values in slots 0..held_count-1.
  logic signed [VAL_W-1:0] held_values [QDEPTH];
  int                      held_count = 0;

  sdq_in_t  op_backlog[$];
  sdq_out_t pending_results[$];
  int       send_idle = 0;
  int       recv_idle = 0;
  int       hold_request = 0;
  int       hold_served = 0;
  int       hold_left = 0;
  int       errors = 0;
  int       cycle_count = 0;
  sdq_out_t oldest;

  function automatic sdq_out_t queue_outcome(sdq_in_t t);
    sdq_out_t r;
    int pos;
    int i;
    r = '0;
    r.status = ST_OK;
    case (t.operation)
      OP_INSERT: begin
        r.result_value = t.item_value;
        if (held_count >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          // A new value goes after every value equal to it.
          pos = 0;
          while (pos < held_count && held_values[pos] <= t.item_value) pos++;
          for (i = held_count; i > pos; i--) held_values[i] = held_values[i-1];
          held_values[pos] = t.item_value;
          held_count++;
        end
      end
      OP_POP_MIN: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.result_value = held_values[0];
          for (i = 0; i + 1 < held_count; i++) held_values[i] = held_values[i+1];
          held_count--;
        end
      end
      OP_POP_MAX: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.result_value = held_values[held_count-1];
          held_count--;
        end
      end
      default: begin
        held_count = 0;
      end
    endcase
    r.entry_count = held_count[4:0];
    return r;
  endfunction

  // Driver: a stalled transaction is held; otherwise the next one is offered or the
  // channel idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      held_count = 0;
    end else begin
      if (in_valid && !in_stall) pending_results.push_back(queue_outcome(in_data));
      if (!(in_valid && in_stall)) begin
        if (op_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          in_data  <= op_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall generator.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transaction: %p", out_data);
          errors++;
        end else begin
          oldest = pending_results.pop_front();
          if (out_data.result_value !== oldest.result_value) begin
            $error("result_value: expected %0d, actual %0d",
                   oldest.result_value, out_data.result_value);
            errors++;
          end
          if (out_data.status !== oldest.status) begin
            $error("status: expected %0d, actual %0d", oldest.status, out_data.status);
            errors++;
          end
          if (out_data.entry_count !== oldest.entry_count) begin
            $error("entry_count: expected %0d, actual %0d",
                   oldest.entry_count, out_data.entry_count);
            errors++;
          end
        end
      end
      if (hold_served != hold_request) begin
        hold_served = hold_request;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic sdq_in_t make_op(sdq_op_t op, logic signed [VAL_W-1:0] v);
    sdq_in_t t;
    t.operation  = op;
    t.item_value = v;
    return t;
  endfunction

  function automatic logic signed [VAL_W-1:0] random_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom;
    if (pick < 8) return $signed($urandom_range(0, 20)) - 10;
    if (pick == 8) return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
    return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff - $urandom_range(0, 3)
                                       : 32'sh80000000 + $urandom_range(0, 3);
  endfunction

  // Runs of fill-heavy, drain-heavy and balanced traffic push the store to both ends.
  task automatic queue_random_ops(int n);
    int mode;
    int r;
    sdq_op_t op;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) mode = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      case (mode)
        0: op = (r < 80) ? OP_INSERT : (r < 89) ? OP_POP_MIN : (r < 98) ? OP_POP_MAX : OP_CLEAR;
        1: op = (r < 20) ? OP_INSERT : (r < 58) ? OP_POP_MIN : (r < 97) ? OP_POP_MAX : OP_CLEAR;
        default:
          op = (r < 48) ? OP_INSERT : (r < 72) ? OP_POP_MIN : (r < 96) ? OP_POP_MAX : OP_CLEAR;
      endcase
      op_backlog.push_back(make_op(op, random_value()));
    end
  endtask

  task automatic wait_idle();
    while (op_backlog.size() != 0 || in_valid || pending_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty-store removals and clear, extremes and ties, full insert.
    send_idle = 19;
    recv_idle = 68;
    op_backlog.push_back(make_op(OP_POP_MIN, 32'sh7fffffff));
    op_backlog.push_back(make_op(OP_POP_MAX, 32'sh80000000));
    op_backlog.push_back(make_op(OP_CLEAR, -1));
    op_backlog.push_back(make_op(OP_INSERT, 32'sh7fffffff));
    op_backlog.push_back(make_op(OP_INSERT, 32'sh80000000));
    op_backlog.push_back(make_op(OP_INSERT, 0));
    op_backlog.push_back(make_op(OP_INSERT, -1));
    op_backlog.push_back(make_op(OP_INSERT, 1));
    op_backlog.push_back(make_op(OP_INSERT, 5));
    op_backlog.push_back(make_op(OP_INSERT, 5));
    op_backlog.push_back(make_op(OP_INSERT, 32'sh7fffffff));
    op_backlog.push_back(make_op(OP_INSERT, 32'sh80000000));
    op_backlog.push_back(make_op(OP_INSERT, 32'sh55555555));
    op_backlog.push_back(make_op(OP_INSERT, 32'shaaaaaaaa));
    op_backlog.push_back(make_op(OP_INSERT, -7));
    op_backlog.push_back(make_op(OP_INSERT, 100));
    op_backlog.push_back(make_op(OP_INSERT, -100));
    op_backlog.push_back(make_op(OP_INSERT, 2));
    op_backlog.push_back(make_op(OP_INSERT, -2));
    op_backlog.push_back(make_op(OP_INSERT, 3));
    op_backlog.push_back(make_op(OP_POP_MAX, 0));
    op_backlog.push_back(make_op(OP_POP_MIN, 0));
    op_backlog.push_back(make_op(OP_CLEAR, 0));
    // The sender pauses here until every result is back.
    wait_idle();

    queue_random_ops(500);
    wait_idle();

    send_idle = 68;
    recv_idle = 19;
    queue_random_ops(500);
    wait_idle();

    // No idling; the receiver holds off long enough for the store to back up its input.
    send_idle = 0;
    recv_idle = 0;
    queue_random_ops(500);
    hold_request++;
    wait_idle();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/sdq_pkg.sv
src/sdq_cell.sv
src/sdq_max_tree.sv
src/sorted_double_ended_queue.sv
bench/sorted_double_ended_queue_test.sv
